FILE: sv/point_cloud_box_normalizer_defines.svh
// Assertion macros for the point cloud box normalizer checker.
`ifndef POINT_CLOUD_BOX_NORMALIZER_DEFINES_SVH
`define POINT_CLOUD_BOX_NORMALIZER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PCBN_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pcbn: same-cycle property failed");

// Next-cycle implication, disabled during reset.
`define PCBN_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pcbn: next-cycle property failed");

`endif

FILE: sv/pcbn_pkg.sv
// Shared types and constants for the point cloud box normalizer.
package pcbn_pkg;
  localparam int MaxPointsDef  = 64;
  localparam int CoordWidthDef = 32;
  localparam int InWidth       = 32;
  localparam int OutWidth      = 32;
  localparam int FracBits      = 30;
  localparam int QuoWidth      = FracBits + 1;
  localparam int DivSteps      = FracBits + 1;
  localparam int StepWidth     = $clog2(DivSteps);
  localparam logic [1:0] AxisLast = 2'd2;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SETUP,
    ST_READ,
    ST_INIT,
    ST_DIV,
    ST_ROUND,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic       load;
    logic       clear;
    logic       setup;
    logic       rd_en;
    logic       div_init;
    logic       div_step;
    logic       div_first;
    logic       round;
    logic [1:0] axis;
  } cmd_t;

  typedef struct packed {
    logic degen;
    logic drop;
  } status_t;
endpackage

FILE: sv/pcbn_datapath.sv
// Datapath: point store, bounds, serial restoring divider and result registers.
module pcbn_datapath #(
  parameter int MAX_POINTS  = pcbn_pkg::MaxPointsDef,
  parameter int COORD_WIDTH = pcbn_pkg::CoordWidthDef,
  localparam int IdxW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
  localparam int CntW = $clog2(MAX_POINTS + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pcbn_pkg::cmd_t                cmd_i,
  input  logic [IdxW-1:0]               rd_addr_i,
  input  logic [pcbn_pkg::InWidth-1:0]  px_i,
  input  logic [pcbn_pkg::InWidth-1:0]  py_i,
  input  logic [pcbn_pkg::InWidth-1:0]  pz_i,
  output logic [CntW-1:0]               count_o,
  output pcbn_pkg::status_t             status_o,
  output logic [pcbn_pkg::OutWidth-1:0] nx_o,
  output logic [pcbn_pkg::OutWidth-1:0] ny_o,
  output logic [pcbn_pkg::OutWidth-1:0] nz_o
);
  import pcbn_pkg::*;

  localparam int CW = (COORD_WIDTH < InWidth) ? COORD_WIDTH : InWidth;

  logic [3*CW-1:0]      mem [MAX_POINTS];
  logic [3*CW-1:0]      rd_q;
  logic [CntW-1:0]      count_q;
  logic                 drop_q;
  logic signed [CW-1:0] min_q [3];
  logic signed [CW-1:0] max_q [3];
  logic signed [CW:0]   sum_q [3];
  logic [CW-1:0]        range_q;
  logic                 degen_q;
  logic [CW:0]          rem_q;
  logic [QuoWidth-1:0]  quo_q;
  logic                 neg_q;
  logic [OutWidth-1:0]  res_q [3];

  logic signed [CW-1:0] p [3];
  logic [CW-1:0]        rng [3];
  logic [CW-1:0]        rng_max;
  logic signed [CW-1:0] q_sel;
  logic signed [CW+1:0] d;
  logic [CW+1:0]        d_mag;
  logic [CW:0]          trial;
  logic [QuoWidth:0]    q_inc;
  logic [OutWidth-1:0]  q_round;
  logic                 room;

  assign p[0] = px_i[CW-1:0];
  assign p[1] = py_i[CW-1:0];
  assign p[2] = pz_i[CW-1:0];
  assign room = count_q < CntW'(MAX_POINTS);

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      rng[a] = CW'(max_q[a] - min_q[a]);
    end
    rng_max = rng[0];
    if (rng[1] > rng_max) rng_max = rng[1];
    if (rng[2] > rng_max) rng_max = rng[2];
  end

  always_comb begin
    case (cmd_i.axis)
      2'd0:    q_sel = rd_q[3*CW-1:2*CW];
      2'd1:    q_sel = rd_q[2*CW-1:CW];
      default: q_sel = rd_q[CW-1:0];
    endcase
    d     = {q_sel[CW-1], q_sel, 1'b0} - {sum_q[cmd_i.axis][CW], sum_q[cmd_i.axis]};
    d_mag = d[CW+1] ? (CW+2)'(-d) : d;
    trial = cmd_i.div_first ? rem_q : {rem_q[CW-1:0], 1'b0};
    q_inc = {1'b0, quo_q} + (QuoWidth+1)'(1);
    q_round = OutWidth'(q_inc[QuoWidth:1]);
    if (neg_q) q_round = OutWidth'(-q_round);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      drop_q  <= 1'b0;
    end else if (cmd_i.clear) begin
      count_q <= '0;
      drop_q  <= 1'b0;
    end else if (cmd_i.load) begin
      if (room) count_q <= count_q + CntW'(1);
      else      drop_q  <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && room) begin
      mem[count_q[IdxW-1:0]] <= {p[0], p[1], p[2]};
      for (int a = 0; a < 3; a++) begin
        if (count_q == '0 || p[a] < min_q[a]) min_q[a] <= p[a];
        if (count_q == '0 || p[a] > max_q[a]) max_q[a] <= p[a];
      end
    end
    if (cmd_i.rd_en) rd_q <= mem[rd_addr_i];
    if (cmd_i.setup) begin
      for (int a = 0; a < 3; a++) begin
        sum_q[a] <= (CW+1)'(max_q[a]) + (CW+1)'(min_q[a]);
      end
      range_q <= rng_max;
      degen_q <= (rng_max == '0);
    end
    if (cmd_i.div_init) begin
      rem_q <= (CW+1)'(d_mag);
      quo_q <= '0;
      neg_q <= d[CW+1];
    end else if (cmd_i.div_step) begin
      if (trial >= {1'b0, range_q}) begin
        rem_q <= trial - {1'b0, range_q};
        quo_q <= {quo_q[QuoWidth-2:0], 1'b1};
      end else begin
        rem_q <= trial;
        quo_q <= {quo_q[QuoWidth-2:0], 1'b0};
      end
    end
    if (cmd_i.round) res_q[cmd_i.axis] <= degen_q ? '0 : q_round;
  end

  assign count_o        = count_q;
  assign status_o.degen = degen_q;
  assign status_o.drop  = drop_q;
  assign nx_o = res_q[0];
  assign ny_o = res_q[1];
  assign nz_o = res_q[2];
endmodule

FILE: sv/pcbn_ctrl.sv
// Controller: sequences loading, setup, per-axis division and output.
module pcbn_ctrl #(
  parameter int MAX_POINTS = pcbn_pkg::MaxPointsDef,
  localparam int IdxW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
  localparam int CntW = $clog2(MAX_POINTS + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic            final_point_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic            end_of_run_o,
  input  logic [CntW-1:0] count_i,
  output pcbn_pkg::cmd_t  cmd_o,
  output logic [IdxW-1:0] rd_addr_o
);
  import pcbn_pkg::*;

  state_e               state_q, state_d;
  logic [IdxW-1:0]      k_q;
  logic [1:0]           axis_q;
  logic [StepWidth-1:0] step_q;
  logic [CntW-1:0]      last_cnt;
  logic                 last_pt;
  logic                 in_acc;
  logic                 out_acc;

  assign last_cnt = count_i - CntW'(1);
  assign last_pt  = (k_q == last_cnt[IdxW-1:0]);
  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_acc  = out_valid_o && !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD:  if (in_acc && final_point_i) state_d = ST_SETUP;
      ST_SETUP: state_d = ST_READ;
      ST_READ:  state_d = ST_INIT;
      ST_INIT:  state_d = ST_DIV;
      ST_DIV:   if (step_q == StepWidth'(DivSteps - 1)) state_d = ST_ROUND;
      ST_ROUND: state_d = (axis_q == AxisLast) ? ST_OUT : ST_INIT;
      ST_OUT:   if (out_acc) state_d = last_pt ? ST_LOAD : ST_READ;
      default:  state_d = ST_LOAD;
    endcase
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.axis      = axis_q;
    in_stall_o      = (state_q != ST_LOAD);
    out_valid_o     = (state_q == ST_OUT);
    end_of_run_o    = last_pt;
    rd_addr_o       = k_q;
    case (state_q)
      ST_LOAD:  cmd_o.load = in_acc;
      ST_SETUP: cmd_o.setup = 1'b1;
      ST_READ:  cmd_o.rd_en = 1'b1;
      ST_INIT:  cmd_o.div_init = 1'b1;
      ST_DIV: begin
        cmd_o.div_step  = 1'b1;
        cmd_o.div_first = (step_q == '0);
      end
      ST_ROUND: cmd_o.round = 1'b1;
      ST_OUT:   cmd_o.clear = out_acc && last_pt;
      default:  cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      k_q     <= '0;
      axis_q  <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_SETUP: k_q <= '0;
        ST_READ:  axis_q <= '0;
        ST_INIT:  step_q <= '0;
        ST_DIV:   step_q <= step_q + StepWidth'(1);
        ST_ROUND: axis_q <= axis_q + 2'd1;
        ST_OUT:   if (out_acc) k_q <= k_q + IdxW'(1);
        default:  ;
      endcase
    end
  end
endmodule

FILE: sv/point_cloud_box_normalizer.sv
// Top level of the point cloud box normalizer.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------------
//  in      | request   | in_valid_i/in_stall_o  | px_i py_i pz_i final_point_i
//  out     | result    | out_valid_o/out_stall_i| nx_o ny_o nz_o degenerate_o
//          |           |                        | overflowed_o end_of_run_o
//
// One request is loaded per cycle while in_stall_o is low; the bounds update in
// the same cycle. After the final request come a setup state, then for each
// stored point a read state and, for each of the 3 axes, the shared serial divider
// (init, 31 quotient steps, round) before the point is offered; it is then held
// in the output state until taken.
// No requests are taken from the final request until the last result is taken.
// Reset is asynchronous, active low; the store needs no clearing pass.
module point_cloud_box_normalizer #(
  parameter int MAX_POINTS  = pcbn_pkg::MaxPointsDef,
  parameter int COORD_WIDTH = pcbn_pkg::CoordWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [pcbn_pkg::InWidth-1:0]  px_i,
  input  logic [pcbn_pkg::InWidth-1:0]  py_i,
  input  logic [pcbn_pkg::InWidth-1:0]  pz_i,
  input  logic                          final_point_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [pcbn_pkg::OutWidth-1:0] nx_o,
  output logic [pcbn_pkg::OutWidth-1:0] ny_o,
  output logic [pcbn_pkg::OutWidth-1:0] nz_o,
  output logic                          degenerate_o,
  output logic                          overflowed_o,
  output logic                          end_of_run_o
);
  import pcbn_pkg::*;

  localparam int IdxW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CntW = $clog2(MAX_POINTS + 1);

  cmd_t            cmd;
  status_t         status;
  logic [IdxW-1:0] rd_addr;
  logic [CntW-1:0] count;

  pcbn_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .final_point_i,
    .out_valid_o, .out_stall_i, .end_of_run_o,
    .count_i(count), .cmd_o(cmd), .rd_addr_o(rd_addr)
  );

  pcbn_datapath #(.MAX_POINTS(MAX_POINTS), .COORD_WIDTH(COORD_WIDTH)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .rd_addr_i(rd_addr),
    .px_i, .py_i, .pz_i, .count_o(count), .status_o(status),
    .nx_o, .ny_o, .nz_o
  );

  assign degenerate_o = status.degen;
  assign overflowed_o = status.drop;
endmodule

FILE: sv/pcbn_checker.sv
// Port-level checker for the point cloud box normalizer, with its bind.
`include "point_cloud_box_normalizer_defines.svh"

module pcbn_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          final_point_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [pcbn_pkg::OutWidth-1:0] nx_o,
  input logic [pcbn_pkg::OutWidth-1:0] ny_o,
  input logic [pcbn_pkg::OutWidth-1:0] nz_o,
  input logic                          degenerate_o,
  input logic                          end_of_run_o
);
  `PCBN_ASSERT_NOW(a_no_req_during_out, out_valid_o, in_stall_o)
  `PCBN_ASSERT_NEXT(a_final_stalls, in_valid_i && !in_stall_o && final_point_i, in_stall_o)
  `PCBN_ASSERT_NEXT(a_run_ends, out_valid_o && !out_stall_i && end_of_run_o, !out_valid_o && !in_stall_o)
  `PCBN_ASSERT_NEXT(a_out_holds, out_valid_o && out_stall_i, out_valid_o && $stable(nx_o) && $stable(ny_o) && $stable(nz_o) && $stable(end_of_run_o))
  `PCBN_ASSERT_NOW(a_degen_zero, out_valid_o && degenerate_o, nx_o == '0 && ny_o == '0 && nz_o == '0)
endmodule

bind point_cloud_box_normalizer pcbn_checker u_pcbn_checker (.*);

FILE: bench/tb_top.sv
// Testbench for the point cloud box normalizer: random point sets checked against a predictor.
`timescale 1ns / 100ps

module tb_top;
  localparam int Capacity = pcbn_pkg::MaxPointsDef;

  typedef struct packed {
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    logic        final_point;
  } point_t;

  typedef struct packed {
    logic [31:0] nx;
    logic [31:0] ny;
    logic [31:0] nz;
    logic        degenerate;
    logic        overflowed;
    logic        end_of_run;
  } norm_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [31:0] px_i = '0, py_i = '0, pz_i = '0;
  logic        final_point_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] nx_o, ny_o, nz_o;
  logic        degenerate_o, overflowed_o, end_of_run_o;

  point_cloud_box_normalizer dut (.*);

  point_t pending_points[$];
  norm_t  expected_norms[$];
  int     mismatches = 0;
  bit     stim_done = 0;
  bit     calm = 0;
  bit     hold = 0;

  logic signed [31:0] pts_x[Capacity], pts_y[Capacity], pts_z[Capacity];
  logic signed [31:0] lo[3], hi[3];
  int  stored = 0;
  bit  dropped = 0;

  function automatic logic [31:0] to_q30(longint d, longint r);
    longint unsigned mag, q, rem;
    bit neg;
    neg = d < 0;
    mag = neg ? -d : d;
    q = 0;
    rem = mag;
    if (rem >= r) begin
      q = 1;
      rem -= r;
    end
    for (int i = 0; i < pcbn_pkg::FracBits; i++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= r) begin
        rem -= r;
        q |= 1;
      end
    end
    q = (q + 1) >> 1;
    if (neg) q = -q;
    return q[31:0];
  endfunction

  task automatic predict_normals(point_t p);
    logic signed [31:0] c[3];
    longint range, ra, sums[3];
    norm_t n;
    c[0] = p.px;
    c[1] = p.py;
    c[2] = p.pz;
    if (stored < Capacity) begin
      pts_x[stored] = c[0];
      pts_y[stored] = c[1];
      pts_z[stored] = c[2];
      for (int a = 0; a < 3; a++) begin
        if (stored == 0 || c[a] < lo[a]) lo[a] = c[a];
        if (stored == 0 || c[a] > hi[a]) hi[a] = c[a];
      end
      stored++;
    end else begin
      dropped = 1;
    end
    if (!p.final_point) return;
    range = 0;
    for (int a = 0; a < 3; a++) begin
      ra = longint'(hi[a]) - longint'(lo[a]);
      if (ra > range) range = ra;
      sums[a] = longint'(hi[a]) + longint'(lo[a]);
    end
    for (int k = 0; k < stored; k++) begin
      n.degenerate = (range == 0);
      n.nx = n.degenerate ? '0 : to_q30(2 * longint'(pts_x[k]) - sums[0], range);
      n.ny = n.degenerate ? '0 : to_q30(2 * longint'(pts_y[k]) - sums[1], range);
      n.nz = n.degenerate ? '0 : to_q30(2 * longint'(pts_z[k]) - sums[2], range);
      n.overflowed = dropped;
      n.end_of_run = (k + 1 == stored);
      expected_norms.push_back(n);
    end
    stored = 0;
    dropped = 0;
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 4095) - 2048;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_set(int count, bit same);
    point_t p;
    p.px = rand_coord();
    p.py = rand_coord();
    p.pz = rand_coord();
    for (int i = 0; i < count; i++) begin
      if (!same) begin
        p.px = rand_coord();
        p.py = rand_coord();
        p.pz = rand_coord();
      end
      p.final_point = (i == count - 1);
      pending_points.push_back(p);
    end
  endtask

  initial forever #10 clk_i = ~clk_i;

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    int total;
    pending_points.push_back('{32'h7fff_ffff, 32'h8000_0000, 32'h0, 1'b0});
    pending_points.push_back('{32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 1'b1});
    add_set(1, 0);
    add_set(3, 1);
    add_set(5, 0);
    add_set(Capacity + 2, 0);
    total = 2 + 1 + 3 + 5 + Capacity + 2;
    while (total < 120) begin
      int c;
      c = $urandom_range(1, 10);
      add_set(c, $urandom_range(0, 9) == 0);
      total += c;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        predict_normals('{px_i, py_i, pz_i, final_point_i});
        void'(pending_points.pop_front());
      end
      if (pending_points.size() > 0 &&
          (calm || $urandom_range(0, 99) >= 34 || (in_valid_i && in_stall_o))) begin
        in_valid_i <= 1'b1;
        px_i <= pending_points[0].px;
        py_i <= pending_points[0].py;
        pz_i <= pending_points[0].pz;
        final_point_i <= pending_points[0].final_point;
      end else begin
        in_valid_i <= 1'b0;
        if (pending_points.size() == 0) stim_done <= 1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_norms.size() == 0) begin
          report_mismatch("unexpected", nx_o, 0);
        end else begin
          norm_t e;
          e = expected_norms.pop_front();
          if (nx_o !== e.nx) report_mismatch("nx", nx_o, e.nx);
          if (ny_o !== e.ny) report_mismatch("ny", ny_o, e.ny);
          if (nz_o !== e.nz) report_mismatch("nz", nz_o, e.nz);
          if (degenerate_o !== e.degenerate) report_mismatch("degenerate", degenerate_o, e.degenerate);
          if (overflowed_o !== e.overflowed) report_mismatch("overflowed", overflowed_o, e.overflowed);
          if (end_of_run_o !== e.end_of_run) report_mismatch("end_of_run", end_of_run_o, e.end_of_run);
        end
      end
      out_stall_i <= hold || (!calm && $urandom_range(0, 99) < 34);
    end
  end

  initial begin
    wait (rst_ni);
    repeat (30) @(posedge clk_i);
    hold = 1;
    repeat (600) @(posedge clk_i);
    hold = 0;
    repeat (2400) @(posedge clk_i);
    calm = 1;
    repeat (4000) @(posedge clk_i);
    calm = 0;
  end

  initial begin
    wait (stim_done);
    wait (expected_norms.size() == 0);
    repeat (300) @(posedge clk_i);
    if (mismatches == 0 && expected_norms.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #40ms;
    $display("Simulation FAILED");
    $finish;
  end
endmodule

FILE: point_cloud_box_normalizer.f
+incdir+sv
sv/pcbn_pkg.sv
sv/pcbn_datapath.sv
sv/pcbn_ctrl.sv
sv/point_cloud_box_normalizer.sv
sv/pcbn_checker.sv
bench/tb_top.sv
